>>> rtl/core/mlts_pkg.sv
package mlts_pkg;

  localparam int MAX_TASKS  = 16;
  localparam int SLOT_W     = $clog2(MAX_TASKS);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int PRIO_W     = 8;
  localparam int TIME_W     = 32;
  localparam int SLICE_W    = 16;
  localparam int LIST_COUNT = 7;
  localparam int LIST_W     = 3;

  localparam logic [LINK_W-1:0] NIL_LINK      = LINK_W'(MAX_TASKS);
  localparam logic [PRIO_W-1:0] IDLE_PRIORITY = PRIO_W'(127);

  // slot states
  localparam logic [2:0] ST_FREE       = 3'd0;
  localparam logic [2:0] ST_AVAILABLE  = 3'd1;
  localparam logic [2:0] ST_ACTIVE     = 3'd2;
  localparam logic [2:0] ST_BLOCKED    = 3'd3;
  localparam logic [2:0] ST_SLEEPING   = 3'd4;
  localparam logic [2:0] ST_TERMINATED = 3'd5;

  // actions
  localparam logic [2:0] ACT_CREATE   = 3'd0;
  localparam logic [2:0] ACT_BLOCK    = 3'd1;
  localparam logic [2:0] ACT_UNBLOCK  = 3'd2;
  localparam logic [2:0] ACT_TICK     = 3'd3;
  localparam logic [2:0] ACT_DISPATCH = 3'd4;

  // block kinds
  localparam logic [1:0] KIND_BLOCKED = 2'd0;
  localparam logic [1:0] KIND_SLEEP   = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // lists: ready queues 0..3, then blocked, sleeping, terminated
  localparam logic [LIST_W-1:0] LIST_BLOCKED    = 3'd4;
  localparam logic [LIST_W-1:0] LIST_SLEEPING   = 3'd5;
  localparam logic [LIST_W-1:0] LIST_TERMINATED = 3'd6;

  // configuration register indexes
  localparam logic [0:0] REG_DEFAULT_PRIORITY = 1'b0;
  localparam logic [0:0] REG_DEFAULT_SLICE    = 1'b1;

  localparam logic [PRIO_W-1:0]  RESET_PRIORITY = PRIO_W'(10);
  localparam logic [SLICE_W-1:0] RESET_SLICE    = SLICE_W'(10);

  typedef struct packed {
    logic [2:0]        state;
    logic [1:0]        policy;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] reload;
    logic [TIME_W-1:0] wake;
  } attr_t;

endpackage

>>> rtl/core/multilevel_task_scheduler.sv
// Multilevel task scheduler. Each word on the input channel is one action
// (create, block running, unblock, tick, dispatch) and yields exactly one result
// word: the running slot, a switch flag, a reject status and slice expiry.
// Slot attributes and the queue links live in two synchronous RAMs of
// MAX_TASKS entries each, with registered reads; list heads and tails are
// registers. Items that walk linked lists through the link RAM take longer
// the more entries they visit. Dispatch keeps a running task in place;
// otherwise it scans ready queue 0, or queue 1 if queue 0 is empty, for the
// best priority and unlinks the pick; with both empty it takes the head of
// queue 2, else of queue 3. A tick visits every sleeper and, for each one
// woken, unlinks it (walking past sleepers still waiting ahead of it) and
// requeues it. One item is processed at a time; a new word is accepted
// while a finished result still waits on the output. Reset leaves both RAMs
// usable at once: per-entry valid bits make unwritten entries read as their
// reset value. Configuration writes take effect at the next edge and must
// be done while idle.
module multilevel_task_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [mlts_pkg::SLICE_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        action,
  input  logic [mlts_pkg::SLOT_W-1:0]       task_id,
  input  logic [1:0]                        policy,
  input  logic [1:0]                        block_kind,
  input  logic [mlts_pkg::TIME_W-1:0]       wake_time,
  input  logic [mlts_pkg::TIME_W-1:0]       time_now,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mlts_pkg::SLOT_W-1:0]       run_slot,
  output logic                              switched,
  output logic                              status,
  output logic                              slice_expired
);

  typedef enum logic [26:0] {
    S_IDLE     = 27'(1) << 0,
    S_DEC      = 27'(1) << 1,
    S_CR_RD    = 27'(1) << 2,
    S_CR_CHK   = 27'(1) << 3,
    S_CR_WR    = 27'(1) << 4,
    S_BK_RD    = 27'(1) << 5,
    S_BK_WR    = 27'(1) << 6,
    S_BK_END   = 27'(1) << 7,
    S_MR_RD    = 27'(1) << 8,
    S_MR_CHK   = 27'(1) << 9,
    S_MR_WR    = 27'(1) << 10,
    S_PU_A     = 27'(1) << 11,
    S_PU_B     = 27'(1) << 12,
    S_DR_GO    = 27'(1) << 13,
    S_DR_RD    = 27'(1) << 14,
    S_DR_CHK   = 27'(1) << 15,
    S_DR_CLR   = 27'(1) << 16,
    S_TK_RD    = 27'(1) << 17,
    S_TK_CHK   = 27'(1) << 18,
    S_TK_NEXT  = 27'(1) << 19,
    S_TK_END   = 27'(1) << 20,
    S_DS_START = 27'(1) << 21,
    S_BS_RD    = 27'(1) << 22,
    S_BS_CHK   = 27'(1) << 23,
    S_DS_RD    = 27'(1) << 24,
    S_DS_WR    = 27'(1) << 25,
    S_DONE     = 27'(1) << 26
  } fsm_t;

  localparam int SW = mlts_pkg::SLOT_W;
  localparam int LW = mlts_pkg::LINK_W;

  fsm_t state, ret, mr_ret;

  // latched input word
  logic [2:0]                   act;
  logic [SW-1:0]                tid;
  logic [1:0]                   pol;
  logic [1:0]                   kind;
  logic [mlts_pkg::TIME_W-1:0]  wake;
  logic [mlts_pkg::TIME_W-1:0]  tnow;

  // configuration and scheduler registers
  logic [mlts_pkg::PRIO_W-1:0]  dflt_prio;
  logic [mlts_pkg::SLICE_W-1:0] dflt_slice;
  logic [SW-1:0]                cur_task;
  logic [mlts_pkg::SLICE_W-1:0] slice_left;
  logic [LW-1:0]                head [mlts_pkg::LIST_COUNT];
  logic [LW-1:0]                tail [mlts_pkg::LIST_COUNT];

  // working registers
  logic [SW-1:0]                tgt;
  logic [mlts_pkg::LIST_W-1:0]  lst;
  logic [LW-1:0]                dr_cur, dr_prev;
  logic [LW-1:0]                tk_cur, tk_nx;
  logic [LW-1:0]                bs_cur, best;
  logic [mlts_pkg::PRIO_W-1:0]  bprio;
  logic [1:0]                   pq;
  mlts_pkg::attr_t              ent;
  logic                         r_sw, r_st, r_exp;

  // attribute RAM
  mlts_pkg::attr_t              amem [mlts_pkg::MAX_TASKS];
  logic [mlts_pkg::MAX_TASKS-1:0] a_vld;
  mlts_pkg::attr_t              a_q, a_rd, a_wd;
  logic                         a_qv, a_qz, a_we;
  logic [SW-1:0]                a_ra;

  // link RAM
  logic [LW-1:0]                lmem [mlts_pkg::MAX_TASKS];
  logic [mlts_pkg::MAX_TASKS-1:0] l_vld;
  logic [LW-1:0]                l_q, l_rd, l_wd;
  logic                         l_qv, l_we;
  logic [SW-1:0]                l_ra, l_wa;

  mlts_pkg::attr_t              idle_ent, free_ent;

  always_comb begin
    idle_ent        = '0;
    idle_ent.state  = mlts_pkg::ST_ACTIVE;
    idle_ent.prio   = mlts_pkg::IDLE_PRIORITY;
    idle_ent.reload = mlts_pkg::IDLE_PRIORITY;
    free_ent        = '0;
    free_ent.state  = mlts_pkg::ST_FREE;
  end

  // entries never written read as their reset value
  assign a_rd = a_qv ? a_q : (a_qz ? idle_ent : free_ent);
  assign l_rd = l_qv ? l_q : mlts_pkg::NIL_LINK;

  always_ff @(posedge clk) begin
    a_q <= amem[a_ra];
    l_q <= lmem[l_ra];
    if (a_we) begin
      amem[tgt] <= a_wd;
    end
    if (l_we) begin
      lmem[l_wa] <= l_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= '0;
      l_vld <= '0;
      a_qv  <= 1'b0;
      a_qz  <= 1'b0;
      l_qv  <= 1'b0;
    end else begin
      a_qv <= a_vld[a_ra];
      a_qz <= (a_ra == '0);
      l_qv <= l_vld[l_ra];
      if (a_we) begin
        a_vld[tgt] <= 1'b1;
      end
      if (l_we) begin
        l_vld[l_wa] <= 1'b1;
      end
    end
  end

  // RAM addresses and write data per state
  always_comb begin
    a_ra = tgt;
    l_ra = tgt;
    a_we = 1'b0;
    a_wd = ent;
    l_we = 1'b0;
    l_wa = tgt;
    l_wd = mlts_pkg::NIL_LINK;
    unique case (state)
      S_TK_RD: begin
        a_ra = tk_cur[SW-1:0];
        l_ra = tk_cur[SW-1:0];
      end
      S_BS_RD: begin
        a_ra = bs_cur[SW-1:0];
        l_ra = bs_cur[SW-1:0];
      end
      S_DR_RD: l_ra = dr_cur[SW-1:0];
      S_CR_WR: begin
        a_we        = 1'b1;
        a_wd.state  = mlts_pkg::ST_AVAILABLE;
        a_wd.policy = pol;
        a_wd.prio   = (pol <= 2'd1) ? dflt_prio : '0;
        a_wd.reload = (pol <= 2'd1) ? dflt_prio : '0;
      end
      S_BK_WR: begin
        a_we       = 1'b1;
        a_wd       = a_rd;
        a_wd.state = mlts_pkg::ST_BLOCKED + 3'(kind);
        if (kind == mlts_pkg::KIND_SLEEP) begin
          a_wd.wake = wake;
        end
      end
      S_MR_WR: begin
        a_we       = 1'b1;
        a_wd.state = mlts_pkg::ST_AVAILABLE;
      end
      S_DS_WR: begin
        a_we       = 1'b1;
        a_wd       = a_rd;
        a_wd.state = mlts_pkg::ST_ACTIVE;
        if (pq <= 2'd1) begin
          a_wd.prio = (a_rd.prio <= mlts_pkg::PRIO_W'(1)) ? a_rd.reload
                                                          : a_rd.prio - 1'b1;
        end
      end
      S_PU_A: l_we = 1'b1;
      S_PU_B: begin
        l_we = (tail[lst] != mlts_pkg::NIL_LINK);
        l_wa = tail[lst][SW-1:0];
        l_wd = {1'b0, tgt};
      end
      S_DR_CHK: begin
        l_we = (dr_cur[SW-1:0] == tgt) && (dr_prev != mlts_pkg::NIL_LINK);
        l_wa = dr_prev[SW-1:0];
        l_wd = l_rd;
      end
      S_DR_CLR: l_we = 1'b1;
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_prio  <= mlts_pkg::RESET_PRIORITY;
      dflt_slice <= mlts_pkg::RESET_SLICE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlts_pkg::REG_DEFAULT_PRIORITY: dflt_prio  <= cfg_data[mlts_pkg::PRIO_W-1:0];
        mlts_pkg::REG_DEFAULT_SLICE:    dflt_slice <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_DONE;
      mr_ret     <= S_DONE;
      cur_task   <= '0;
      slice_left <= mlts_pkg::RESET_SLICE;
      out_valid  <= 1'b0;
      for (int i = 0; i < mlts_pkg::LIST_COUNT; i++) begin
        head[i] <= mlts_pkg::NIL_LINK;
        tail[i] <= mlts_pkg::NIL_LINK;
      end
    end else begin
      // drop the taken word unless a new one replaces it this cycle
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act   <= action;
            tid   <= task_id;
            pol   <= policy;
            kind  <= block_kind;
            wake  <= wake_time;
            tnow  <= time_now;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          r_sw  <= 1'b0;
          r_st  <= 1'b0;
          r_exp <= 1'b0;
          unique case (act)
            mlts_pkg::ACT_CREATE: begin
              tgt <= tid;
              if (tid == '0) begin
                r_st  <= 1'b1;
                state <= S_DONE;
              end else begin
                state <= S_CR_RD;
              end
            end
            mlts_pkg::ACT_BLOCK: begin
              tgt <= cur_task;
              if (kind == mlts_pkg::KIND_INVALID || cur_task == '0) begin
                r_st  <= 1'b1;
                state <= S_DONE;
              end else begin
                state <= S_BK_RD;
              end
            end
            mlts_pkg::ACT_UNBLOCK: begin
              tgt    <= tid;
              mr_ret <= S_DONE;
              if (tid == '0) begin
                r_st  <= 1'b1;
                state <= S_DONE;
              end else begin
                state <= S_MR_RD;
              end
            end
            mlts_pkg::ACT_TICK: begin
              tk_cur <= head[mlts_pkg::LIST_SLEEPING];
              state  <= S_TK_RD;
            end
            mlts_pkg::ACT_DISPATCH: state <= S_DS_START;
            default: begin
              r_st  <= 1'b1;
              state <= S_DONE;
            end
          endcase
        end

        // create
        S_CR_RD: state <= S_CR_CHK;
        S_CR_CHK: begin
          ent <= a_rd;
          if (a_rd.state == mlts_pkg::ST_TERMINATED) begin
            lst   <= mlts_pkg::LIST_TERMINATED;
            ret   <= S_CR_WR;
            state <= S_DR_GO;
          end else if (a_rd.state == mlts_pkg::ST_FREE) begin
            state <= S_CR_WR;
          end else begin
            r_st  <= 1'b1;
            state <= S_DONE;
          end
        end
        S_CR_WR: begin
          lst   <= mlts_pkg::LIST_W'(pol);
          ret   <= S_DONE;
          state <= S_PU_A;
        end

        // block running task, then dispatch
        S_BK_RD: state <= S_BK_WR;
        S_BK_WR: begin
          lst   <= mlts_pkg::LIST_BLOCKED + mlts_pkg::LIST_W'(kind);
          ret   <= S_BK_END;
          state <= S_PU_A;
        end
        S_BK_END: begin
          cur_task   <= '0;
          slice_left <= dflt_slice;
          state      <= S_DS_START;
        end

        // move a parked task back to its ready queue
        S_MR_RD: state <= S_MR_CHK;
        S_MR_CHK: begin
          ent <= a_rd;
          if (a_rd.state == mlts_pkg::ST_BLOCKED || a_rd.state == mlts_pkg::ST_SLEEPING ||
              a_rd.state == mlts_pkg::ST_TERMINATED) begin
            lst   <= mlts_pkg::LIST_BLOCKED + (a_rd.state - mlts_pkg::ST_BLOCKED);
            ret   <= S_MR_WR;
            state <= S_DR_GO;
          end else begin
            r_st  <= 1'b1;
            state <= mr_ret;
          end
        end
        S_MR_WR: begin
          lst   <= mlts_pkg::LIST_W'(ent.policy);
          ret   <= mr_ret;
          state <= S_PU_A;
        end

        // append tgt to list lst
        S_PU_A: state <= S_PU_B;
        S_PU_B: begin
          if (tail[lst] == mlts_pkg::NIL_LINK) begin
            head[lst] <= {1'b0, tgt};
          end
          tail[lst] <= {1'b0, tgt};
          state     <= ret;
        end

        // unlink tgt from list lst
        S_DR_GO: begin
          dr_cur  <= head[lst];
          dr_prev <= mlts_pkg::NIL_LINK;
          state   <= S_DR_RD;
        end
        S_DR_RD: begin
          state <= (dr_cur == mlts_pkg::NIL_LINK) ? ret : S_DR_CHK;
        end
        S_DR_CHK: begin
          if (dr_cur[SW-1:0] == tgt) begin
            if (dr_prev == mlts_pkg::NIL_LINK) begin
              head[lst] <= l_rd;
            end
            if (tail[lst] == {1'b0, tgt}) begin
              tail[lst] <= dr_prev;
            end
            state <= S_DR_CLR;
          end else begin
            dr_prev <= dr_cur;
            dr_cur  <= l_rd;
            state   <= S_DR_RD;
          end
        end
        S_DR_CLR: state <= ret;

        // tick: wake due sleepers, count down the slice
        S_TK_RD: begin
          state <= (tk_cur == mlts_pkg::NIL_LINK) ? S_TK_END : S_TK_CHK;
        end
        S_TK_CHK: begin
          tk_nx <= l_rd;
          if (tnow >= a_rd.wake) begin
            tgt    <= tk_cur[SW-1:0];
            mr_ret <= S_TK_NEXT;
            state  <= S_MR_RD;
          end else begin
            tk_cur <= l_rd;
            state  <= S_TK_RD;
          end
        end
        S_TK_NEXT: begin
          tk_cur <= tk_nx;
          state  <= S_TK_RD;
        end
        S_TK_END: begin
          if (slice_left <= mlts_pkg::SLICE_W'(1)) begin
            r_exp      <= 1'b1;
            slice_left <= dflt_slice;
          end else begin
            slice_left <= slice_left - 1'b1;
          end
          state <= S_DONE;
        end

        // dispatch, when no task runs: best priority of queue 0, then 1, then heads of 2 and 3
        S_DS_START: begin
          pq     <= 2'd0;
          bs_cur <= head[0];
          best   <= mlts_pkg::NIL_LINK;
          state  <= (cur_task != '0) ? S_DONE : S_BS_RD;
        end
        S_BS_RD: begin
          if (bs_cur != mlts_pkg::NIL_LINK) begin
            state <= S_BS_CHK;
          end else if (best != mlts_pkg::NIL_LINK) begin
            tgt   <= best[SW-1:0];
            lst   <= mlts_pkg::LIST_W'(pq);
            ret   <= S_DS_RD;
            state <= S_DR_GO;
          end else if (pq == 2'd0) begin
            pq     <= 2'd1;
            bs_cur <= head[1];
          end else if (head[2] != mlts_pkg::NIL_LINK) begin
            pq    <= 2'd2;
            tgt   <= head[2][SW-1:0];
            lst   <= mlts_pkg::LIST_W'(2);
            ret   <= S_DS_RD;
            state <= S_DR_GO;
          end else if (head[3] != mlts_pkg::NIL_LINK) begin
            pq    <= 2'd3;
            tgt   <= head[3][SW-1:0];
            lst   <= mlts_pkg::LIST_W'(3);
            ret   <= S_DS_RD;
            state <= S_DR_GO;
          end else begin
            state <= S_DONE;
          end
        end
        S_BS_CHK: begin
          if (best == mlts_pkg::NIL_LINK || a_rd.prio > bprio) begin
            best  <= bs_cur;
            bprio <= a_rd.prio;
          end
          bs_cur <= l_rd;
          state  <= S_BS_RD;
        end
        S_DS_RD: state <= S_DS_WR;
        S_DS_WR: begin
          cur_task   <= tgt;
          slice_left <= dflt_slice;
          r_sw       <= 1'b1;
          state      <= S_DONE;
        end

        // hold the result until the output register is free
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            run_slot      <= cur_task;
            switched      <= r_sw;
            status        <= r_st;
            slice_expired <= r_exp;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // ---------------------------------------------------------------------------
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [0:0]                   cfg_index = '0;
  logic [mlts_pkg::SLICE_W-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [2:0]                   action = '0;
  logic [mlts_pkg::SLOT_W-1:0]  task_id = '0;
  logic [1:0]                   policy = '0;
  logic [1:0]                   block_kind = '0;
  logic [mlts_pkg::TIME_W-1:0]  wake_time = '0;
  logic [mlts_pkg::TIME_W-1:0]  time_now = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [mlts_pkg::SLOT_W-1:0]  run_slot;
  logic                         switched;
  logic                         status;
  logic                         slice_expired;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multilevel_task_scheduler i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .task_id(task_id), .policy(policy),
    .block_kind(block_kind), .wake_time(wake_time), .time_now(time_now),
    .out_valid(out_valid), .out_stall(out_stall),
    .run_slot(run_slot), .switched(switched),
    .status(status), .slice_expired(slice_expired)
  );

  localparam logic [2:0] ACT_BAD  = 3'd5;  // first of the unused action codes
  localparam logic [2:0] ACT_LAST = 3'd7;  // last of the unused action codes
  localparam logic [1:0] KIND_TERM = 2'd2;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_DIR = 23;

  typedef struct packed {
    logic [mlts_pkg::SLOT_W-1:0] run;
    logic                        sw;
    logic                        st;
    logic                        exp;
  } sched_word_t;

  // ---------------------------------------------------------------------------
  // Scheduler shadow: own copy of slot table, lists and configuration
  // ---------------------------------------------------------------------------
  logic [mlts_pkg::PRIO_W-1:0]  cfg_prio;
  logic [mlts_pkg::SLICE_W-1:0] cfg_slice;
  logic [2:0]                   sh_state [mlts_pkg::MAX_TASKS];
  logic [1:0]                   sh_pol   [mlts_pkg::MAX_TASKS];
  logic [mlts_pkg::PRIO_W-1:0]  sh_prio  [mlts_pkg::MAX_TASKS];
  logic [mlts_pkg::PRIO_W-1:0]  sh_reload[mlts_pkg::MAX_TASKS];
  logic [mlts_pkg::TIME_W-1:0]  sh_wake  [mlts_pkg::MAX_TASKS];
  int                           sh_next  [mlts_pkg::MAX_TASKS];
  int                           sh_head  [mlts_pkg::LIST_COUNT];
  int                           sh_tail  [mlts_pkg::LIST_COUNT];
  int                           sh_run;
  logic [mlts_pkg::SLICE_W-1:0] sh_slice;
  logic [mlts_pkg::TIME_W-1:0]  sys_time;  // monotonic clock fed to ticks

  sched_word_t expected_words[$];
  int errors = 0;
  int n_results = 0;
  int n_switch = 0;
  int n_expire = 0;
  int n_reject = 0;
  int idle_cycles = 0;
  int send_pct = 0, recv_pct = 0;

  function automatic void shadow_reset();
    cfg_prio = mlts_pkg::RESET_PRIORITY;
    cfg_slice = mlts_pkg::RESET_SLICE;
    for (int i = 0; i < mlts_pkg::MAX_TASKS; i++) begin
      sh_state[i] = mlts_pkg::ST_FREE; sh_pol[i] = '0; sh_prio[i] = '0; sh_reload[i] = '0;
      sh_wake[i] = '0; sh_next[i] = mlts_pkg::MAX_TASKS;
    end
    for (int i = 0; i < mlts_pkg::LIST_COUNT; i++) begin
      sh_head[i] = mlts_pkg::MAX_TASKS; sh_tail[i] = mlts_pkg::MAX_TASKS;
    end
    sh_state[0] = mlts_pkg::ST_ACTIVE;
    sh_prio[0] = mlts_pkg::IDLE_PRIORITY;
    sh_reload[0] = mlts_pkg::IDLE_PRIORITY;
    sh_run = 0;
    sh_slice = mlts_pkg::RESET_SLICE;
  endfunction

  function automatic void queue_append(int l, int t);
    sh_next[t] = mlts_pkg::MAX_TASKS;
    if (sh_tail[l] >= mlts_pkg::MAX_TASKS) sh_head[l] = t;
    else sh_next[sh_tail[l]] = t;
    sh_tail[l] = t;
  endfunction

  function automatic void queue_unlink(int l, int t);
    int prev, cur;
    prev = mlts_pkg::MAX_TASKS;
    cur = sh_head[l];
    for (int n = 0; n < mlts_pkg::MAX_TASKS && cur < mlts_pkg::MAX_TASKS; n++) begin
      if (cur == t) begin
        if (prev >= mlts_pkg::MAX_TASKS) sh_head[l] = sh_next[cur];
        else sh_next[prev] = sh_next[cur];
        if (sh_tail[l] == t) sh_tail[l] = prev;
        sh_next[cur] = mlts_pkg::MAX_TASKS;
        return;
      end
      prev = cur;
      cur = sh_next[cur];
    end
  endfunction

  function automatic bit requeue_parked(int t);
    logic [2:0] s;
    s = sh_state[t];
    if (s != mlts_pkg::ST_BLOCKED && s != mlts_pkg::ST_SLEEPING &&
        s != mlts_pkg::ST_TERMINATED) return 0;
    queue_unlink(int'(mlts_pkg::LIST_BLOCKED + (s - mlts_pkg::ST_BLOCKED)), t);
    sh_state[t] = mlts_pkg::ST_AVAILABLE;
    queue_append(int'(sh_pol[t]), t);
    return 1;
  endfunction

  // Highest priority in a ready queue; first one wins a tie.
  function automatic int top_priority(int q);
    int cur, best;
    best = mlts_pkg::MAX_TASKS;
    cur = sh_head[q];
    for (int n = 0; n < mlts_pkg::MAX_TASKS && cur < mlts_pkg::MAX_TASKS; n++) begin
      if (best >= mlts_pkg::MAX_TASKS || sh_prio[cur] > sh_prio[best]) best = cur;
      cur = sh_next[cur];
    end
    return best;
  endfunction

  function automatic bit pick_next();
    int pick;
    pick = mlts_pkg::MAX_TASKS;
    if (sh_run != 0) return 0;
    for (int q = 0; q < 2 && pick >= mlts_pkg::MAX_TASKS; q++) begin
      pick = top_priority(q);
      if (pick < mlts_pkg::MAX_TASKS) begin
        if (sh_prio[pick] <= mlts_pkg::PRIO_W'(1)) sh_prio[pick] = sh_reload[pick];
        else sh_prio[pick] = sh_prio[pick] - mlts_pkg::PRIO_W'(1);
      end
    end
    if (pick >= mlts_pkg::MAX_TASKS) pick = sh_head[2];
    if (pick >= mlts_pkg::MAX_TASKS) pick = sh_head[3];
    if (pick >= mlts_pkg::MAX_TASKS) return 0;
    queue_unlink(int'(sh_pol[pick]), pick);
    sh_state[pick] = mlts_pkg::ST_ACTIVE;
    sh_run = pick;
    sh_slice = cfg_slice;
    return 1;
  endfunction

  // Advance the shadow by one action and return the word it should produce.
  function automatic sched_word_t schedule_step(logic [2:0] act, int tid, logic [1:0] pol,
                                                logic [1:0] kind,
                                                logic [mlts_pkg::TIME_W-1:0] wake,
                                                logic [mlts_pkg::TIME_W-1:0] now);
    sched_word_t r;
    int cur, nx, c;
    r = '0;
    case (act)
      mlts_pkg::ACT_CREATE: begin
        if (tid == 0 || (sh_state[tid] != mlts_pkg::ST_FREE &&
                         sh_state[tid] != mlts_pkg::ST_TERMINATED)) begin
          r.st = 1'b1;
        end else begin
          if (sh_state[tid] == mlts_pkg::ST_TERMINATED)
            queue_unlink(int'(mlts_pkg::LIST_TERMINATED), tid);
          sh_state[tid] = mlts_pkg::ST_AVAILABLE;
          sh_pol[tid] = pol;
          sh_prio[tid] = (pol <= 2'd1) ? cfg_prio : '0;
          sh_reload[tid] = sh_prio[tid];
          queue_append(int'(pol), tid);
        end
      end
      mlts_pkg::ACT_BLOCK: begin
        c = sh_run;
        if (kind == mlts_pkg::KIND_INVALID || c == 0) begin
          r.st = 1'b1;
        end else begin
          if (kind == mlts_pkg::KIND_SLEEP) sh_wake[c] = wake;
          sh_state[c] = mlts_pkg::ST_BLOCKED + 3'(kind);
          queue_append(int'(mlts_pkg::LIST_BLOCKED + 3'(kind)), c);
          sh_run = 0;
          sh_slice = cfg_slice;
          r.sw = pick_next();
        end
      end
      mlts_pkg::ACT_UNBLOCK: begin
        if (tid == 0 || !requeue_parked(tid)) r.st = 1'b1;
      end
      mlts_pkg::ACT_TICK: begin
        cur = sh_head[mlts_pkg::LIST_SLEEPING];
        for (int n = 0; n < mlts_pkg::MAX_TASKS && cur < mlts_pkg::MAX_TASKS; n++) begin
          nx = sh_next[cur];
          if (now >= sh_wake[cur]) begin
            sh_wake[cur] = '0;
            void'(requeue_parked(cur));
          end
          cur = nx;
        end
        if (sh_slice <= mlts_pkg::SLICE_W'(1)) begin
          r.exp = 1'b1;
          sh_slice = cfg_slice;
        end else begin
          sh_slice = sh_slice - mlts_pkg::SLICE_W'(1);
        end
      end
      mlts_pkg::ACT_DISPATCH: r.sw = pick_next();
      default: r.st = 1'b1;
    endcase
    r.run = sh_run[mlts_pkg::SLOT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall, compare against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin : check_word
      sched_word_t got, want;
      got = '{run_slot, switched, status, slice_expired};
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result word %p", got);
      end else begin
        want = expected_words.pop_front();
        n_results++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"ERROR: result %0d: expected run=%0d sw=%0b st=%0b exp=%0b,",
                      " got run=%0d sw=%0b st=%0b exp=%0b"},
                     n_results, want.run, want.sw, want.st, want.exp,
                     got.run, got.sw, got.st, got.exp);
        end
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_pct);

  // Watchdog: count cycles with no accepted word on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", expected_words.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Present one action word, hold it through stalls, predict on acceptance.
  // Valid stays high once the word is taken; a later call or the drain drops it.
  task automatic send_word(logic [2:0] act, logic [mlts_pkg::SLOT_W-1:0] tid, logic [1:0] pol,
                           logic [1:0] kind, logic [mlts_pkg::TIME_W-1:0] wake,
                           logic [mlts_pkg::TIME_W-1:0] now, bit check_typed,
                           sched_word_t typed);
    sched_word_t pred;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    action <= act; task_id <= tid; policy <= pol; block_kind <= kind;
    wake_time <= wake; time_now <= now;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = schedule_step(act, int'(tid), pol, kind, wake, now);
    if (check_typed && pred !== typed) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: directed row act=%0d tid=%0d: typed %p, predicted %p",
                 act, tid, typed, pred);
    end
    expected_words.push_back(check_typed ? typed : pred);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [mlts_pkg::SLICE_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mlts_pkg::REG_DEFAULT_PRIORITY) cfg_prio = val[mlts_pkg::PRIO_W-1:0];
    else cfg_slice = val;
    @(negedge clk);
  endtask

  // Directed rows: typed flag says the expected word is read off directly.
  typedef struct {
    logic [2:0] act; logic [mlts_pkg::SLOT_W-1:0] tid; logic [1:0] pol; logic [1:0] kind;
    logic [mlts_pkg::TIME_W-1:0] wake; logic [mlts_pkg::TIME_W-1:0] now;
    bit typed; sched_word_t res;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    '{mlts_pkg::ACT_DISPATCH, 4'd0,  2'd0, 2'd0, 32'd0, 32'd0, 1, '{4'd0, 1'b0, 1'b0, 1'b0}},
    '{mlts_pkg::ACT_BLOCK,    4'd0,  2'd0, 2'd0, 32'd0, 32'd0, 1, '{4'd0, 1'b0, 1'b1, 1'b0}},
    '{mlts_pkg::ACT_CREATE,   4'd0,  2'd0, 2'd0, 32'd0, 32'd0, 1, '{4'd0, 1'b0, 1'b1, 1'b0}},
    '{mlts_pkg::ACT_UNBLOCK,  4'd0,  2'd0, 2'd0, 32'd0, 32'd0, 1, '{4'd0, 1'b0, 1'b1, 1'b0}},
    '{mlts_pkg::ACT_UNBLOCK,  4'd5,  2'd0, 2'd0, 32'd0, 32'd0, 1, '{4'd0, 1'b0, 1'b1, 1'b0}},
    '{ACT_BAD,                4'd3,  2'd1, 2'd1, 32'd0, 32'd0, 1, '{4'd0, 1'b0, 1'b1, 1'b0}},
    '{ACT_LAST, 4'd15, 2'd3, mlts_pkg::KIND_INVALID, '1, '1, 1, '{4'd0, 1'b0, 1'b1, 1'b0}},
    '{mlts_pkg::ACT_CREATE,   4'd15, 2'd3, 2'd0, 32'd0, 32'd0, 0, '0},
    '{mlts_pkg::ACT_CREATE,   4'd15, 2'd0, 2'd0, 32'd0, 32'd0, 1, '{4'd0, 1'b0, 1'b1, 1'b0}},
    '{mlts_pkg::ACT_CREATE,   4'd1,  2'd0, 2'd0, 32'd0, 32'd0, 0, '0},
    '{mlts_pkg::ACT_CREATE,   4'd2,  2'd1, 2'd0, 32'd0, 32'd0, 0, '0},
    '{mlts_pkg::ACT_CREATE,   4'd3,  2'd2, 2'd0, 32'd0, 32'd0, 0, '0},
    '{mlts_pkg::ACT_DISPATCH, 4'd0,  2'd0, 2'd0, 32'd0, 32'd0, 1, '{4'd1, 1'b1, 1'b0, 1'b0}},
    '{mlts_pkg::ACT_DISPATCH, 4'd0,  2'd0, 2'd0, 32'd0, 32'd0, 1, '{4'd1, 1'b0, 1'b0, 1'b0}},
    '{mlts_pkg::ACT_BLOCK, 4'd0, 2'd0, mlts_pkg::KIND_INVALID, 32'd0, 32'd0,
      1, '{4'd1, 1'b0, 1'b1, 1'b0}},
    '{mlts_pkg::ACT_BLOCK, 4'd0, 2'd0, mlts_pkg::KIND_SLEEP, '1, 32'd0, 0, '0},
    '{mlts_pkg::ACT_TICK,     4'd0,  2'd0, 2'd0, 32'd0, 32'hFFFF_FFFE, 0, '0},
    '{mlts_pkg::ACT_TICK,     4'd0,  2'd0, 2'd0, 32'd0, '1,    0, '0},
    '{mlts_pkg::ACT_BLOCK, 4'd0, 2'd0, mlts_pkg::KIND_BLOCKED, 32'd0, 32'd0, 0, '0},
    '{mlts_pkg::ACT_BLOCK,    4'd0,  2'd0, KIND_TERM, 32'd0, 32'd0, 0, '0},
    '{mlts_pkg::ACT_CREATE,   4'd3,  2'd1, 2'd0, 32'd0, 32'd0, 0, '0},
    '{mlts_pkg::ACT_UNBLOCK,  4'd2,  2'd0, 2'd0, 32'd0, 32'd0, 0, '0},
    '{mlts_pkg::ACT_UNBLOCK,  4'd2,  2'd0, 2'd0, 32'd0, 32'd0, 1, '{4'd3, 1'b0, 1'b1, 1'b0}}
  };

  // Random word, mostly well formed: create into random slots, block the runner,
  // unblock parked tasks, ticks at a rising time near the sleepers' wake times.
  task automatic send_random_word();
    int r;
    logic [2:0] act;
    logic [mlts_pkg::SLOT_W-1:0] tid;
    logic [1:0] kd;
    logic [mlts_pkg::TIME_W-1:0] wk, nw;
    r = $urandom_range(99);
    tid = mlts_pkg::SLOT_W'($urandom_range(mlts_pkg::MAX_TASKS - 1));
    if (r < 20) act = mlts_pkg::ACT_CREATE;
    else if (r < 38) act = mlts_pkg::ACT_BLOCK;
    else if (r < 55) act = mlts_pkg::ACT_UNBLOCK;
    else if (r < 78) act = mlts_pkg::ACT_TICK;
    else if (r < 97) act = mlts_pkg::ACT_DISPATCH;
    else act = 3'($urandom_range(int'(ACT_LAST), int'(ACT_BAD)));
    if (act == mlts_pkg::ACT_UNBLOCK && $urandom_range(3) != 0)
      for (int i = 0; i < mlts_pkg::MAX_TASKS; i++)
        if (sh_state[(int'(tid) + i) % mlts_pkg::MAX_TASKS] >= mlts_pkg::ST_BLOCKED) begin
          tid = mlts_pkg::SLOT_W'((int'(tid) + i) % mlts_pkg::MAX_TASKS);
          break;
        end
    if (act == mlts_pkg::ACT_TICK) sys_time = sys_time + mlts_pkg::TIME_W'($urandom_range(3));
    nw = ($urandom_range(19) == 0) ? mlts_pkg::TIME_W'($urandom) : sys_time;
    wk = ($urandom_range(9) == 0) ? mlts_pkg::TIME_W'($urandom)
                                  : sys_time + mlts_pkg::TIME_W'($urandom_range(6));
    kd = ($urandom_range(9) == 0) ? mlts_pkg::KIND_INVALID : 2'($urandom_range(2));
    send_word(act, tid, 2'($urandom_range(3)), kd, wk, nw, 0, '0);
  endtask

  initial begin
    shadow_reset();
    sys_time = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with reset configuration, no idling.
    foreach (dir_rows[i])
      send_word(dir_rows[i].act, dir_rows[i].tid, dir_rows[i].pol, dir_rows[i].kind,
                dir_rows[i].wake, dir_rows[i].now, dir_rows[i].typed, dir_rows[i].res);
    wait_drained();  // sender holds off until every result is back

    // Random phases: each picks a configuration and an idling mix.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 88; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 88; end
        default: begin send_pct = 22; recv_pct = 22; end
      endcase
      case (ph)
        0: begin
          write_reg(mlts_pkg::REG_DEFAULT_PRIORITY, 16'd1);
          write_reg(mlts_pkg::REG_DEFAULT_SLICE, 16'd1);
        end
        1: begin
          write_reg(mlts_pkg::REG_DEFAULT_PRIORITY, 16'd255);
          write_reg(mlts_pkg::REG_DEFAULT_SLICE, 16'hFFFF);
        end
        2: begin
          write_reg(mlts_pkg::REG_DEFAULT_PRIORITY, 16'd2);
          write_reg(mlts_pkg::REG_DEFAULT_SLICE, 16'd3);
        end
        default: begin
          write_reg(mlts_pkg::REG_DEFAULT_PRIORITY, 16'($urandom_range(1, 255)));
          write_reg(mlts_pkg::REG_DEFAULT_SLICE, 16'($urandom_range(1, 12)));
        end
      endcase
      repeat (228) send_random_word();
      wait_drained();
    end

    $display("covered %0d result words: %0d task switches, %0d slice expiries, %0d rejects",
             n_results, n_switch, n_expire, n_reject);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

  // Tally what the run exercised, from the words seen on the output.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) begin
      n_switch <= n_switch + int'(switched);
      n_expire <= n_expire + int'(slice_expired);
      n_reject <= n_reject + int'(status);
    end

endmodule
